[rtl/lcts_pkg.sv]
// Shared types and codes for the latency-corrected trigger scheduler.
// No dependencies; used by the core and its testbench.
`default_nettype none
package lcts_pkg;

    localparam int unsigned CmdTimeW = 46;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned TolW     = 20;
    localparam int unsigned IntvW    = 24;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_REQUEST = 3'd1;
    localparam logic [2:0] MODE_ECHO    = 3'd2;
    localparam logic [2:0] MODE_SESSION = 3'd3;
    localparam logic [2:0] MODE_LINK    = 3'd4;

    localparam logic [1:0] KIND_FIRE     = 2'd0;
    localparam logic [1:0] KIND_PULSE    = 2'd1;
    localparam logic [1:0] KIND_DECISION = 2'd2;
    localparam logic [1:0] KIND_LATENCY  = 2'd3;

    localparam logic [1:0] SESSION_STOPPED = 2'd0;
    localparam logic [1:0] SESSION_STARTED = 2'd1;

    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_INTERVAL  = 1'b1;

    localparam logic [IntvW-1:0] IntervalReset = 24'd100000;

    typedef struct packed {
        logic [2:0]          mode;
        logic [CmdTimeW-1:0] time_us;
        logic [1:0]          session_code;
        logic                link_on;
    } cmd_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CmdTimeW-1:0] fire_time;
        logic signed [47:0]  corrected_time;
        logic signed [31:0]  latency_now;
        logic                accepted;
        logic                last;
    } res_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_SDRAIN = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_MOVE   = 7'b0010000,
        ST_PULSE  = 7'b0100000,
        ST_FLUSH  = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

[rtl/lcts_queue_mem.sv]
// Pending trigger time store: one write port, one read port, registered read.
// Depends on nothing outside this file.
`default_nettype none
module lcts_queue_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 46
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/latency_corrected_trigger_scheduler_core.sv]
// Top level of the latency-corrected trigger scheduler.
// Depends on lcts_pkg and lcts_queue_mem.
`default_nettype none
// Commands enter on start while busy is low. Request, echo, session and link
// commands finish in the cycle they are taken; a request or echo gives one
// result beat on the following cycle. A sample tick in a started session
// searches the queue for its earliest entry by reading the queue memory one
// entry a cycle (the search ends by also reading the tail entry), fires it if
// due and the link is up (moving the tail entry into the freed slot), and
// repeats; then it decides on the measurement pulse and flushes the final
// beat. The final beat of a tick comes out in the same cycle that busy drops.
// Result beats appear for exactly one cycle on res, marked by res_valid, with
// res.last on the final beat of each command; the receiver cannot stall them.
module latency_corrected_trigger_scheduler_core #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TIME_BITS   = 46
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire lcts_pkg::cmd_t             cmd,
    output logic                            res_valid,
    output lcts_pkg::res_t                  res,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [lcts_pkg::CfgDataW-1:0] cfg_data
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CountFull = CW'(QUEUE_DEPTH);
    localparam logic signed [63:0] Corr48Max = 64'sd140737488355327;
    localparam logic signed [63:0] Corr48Min = -64'sd140737488355328;
    localparam logic signed [63:0] Lat32Max  = 64'sd2147483647;
    localparam logic signed [63:0] Lat32Min  = -64'sd2147483648;

    // configuration
    logic [lcts_pkg::TolW-1:0]  tol_reg;
    logic [lcts_pkg::IntvW-1:0] intv_reg;

    // scheduler state
    lcts_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]        count_reg;
    logic signed [31:0]   lat_reg;
    logic [TIME_BITS-1:0] pulse_t_reg;
    logic signed [47:0]   corr_reg;
    logic [1:0]           session_reg;
    logic                 link_reg;
    logic [TIME_BITS-1:0] tick_t_reg;

    // search
    logic [AW-1:0]        idx_reg;
    logic                 rv_reg;
    logic [AW-1:0]        rv_idx_reg;
    logic [AW-1:0]        best_idx_reg;
    logic [TIME_BITS-1:0] best_val_reg;

    // held beat: the newest result of a tick waits here until its successor
    // or the end of the tick tells whether it is the last one
    logic                 hold_valid_reg;
    lcts_pkg::res_t       hold_reg;

    // memory ports
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [TIME_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [TIME_BITS-1:0] mem_rdata;

    logic [61:0]          t_wide;
    logic [TIME_BITS-1:0] t_in;
    logic signed [63:0]   t_s;
    logic signed [63:0]   corr_sum;
    logic signed [47:0]   corr_sat;
    logic signed [63:0]   lat_diff;
    logic signed [31:0]   lat_sat;
    logic                 req_ok;
    logic                 take;
    logic [CW-1:0]        count_m1;
    logic                 due;
    logic signed [63:0]   pulse_gap;
    logic                 pulse_ok;

    assign take     = start && !busy;
    assign busy     = (state_reg != lcts_pkg::ST_IDLE);
    assign t_wide   = 62'(cmd.time_us);
    assign t_in     = t_wide[TIME_BITS-1:0];
    assign t_s      = $signed(64'(t_in));
    assign count_m1 = count_reg - CW'(1);

    // corrected time = sample time + latency, clipped to 48 bits
    assign corr_sum = t_s + 64'(lat_reg);
    always_comb
    begin
        if (corr_sum > Corr48Max)
        begin
            corr_sat = 48'(Corr48Max);
        end
        else if (corr_sum < Corr48Min)
        begin
            corr_sat = 48'(Corr48Min);
        end
        else
        begin
            corr_sat = corr_sum[47:0];
        end
    end

    // latency = echo time - last pulse time, clipped to 32 bits
    assign lat_diff = t_s - $signed(64'(pulse_t_reg));
    always_comb
    begin
        if (lat_diff > Lat32Max)
        begin
            lat_sat = 32'(Lat32Max);
        end
        else if (lat_diff < Lat32Min)
        begin
            lat_sat = 32'(Lat32Min);
        end
        else
        begin
            lat_sat = lat_diff[31:0];
        end
    end

    assign req_ok = link_reg && (count_reg < CountFull) &&
                    (t_s > (64'(corr_reg) - $signed(64'(tol_reg))));
    assign due    = $signed(64'(best_val_reg)) <= 64'(corr_reg);
    assign pulse_gap = $signed(64'(tick_t_reg)) - $signed(64'(pulse_t_reg));
    assign pulse_ok  = link_reg && (pulse_gap >= $signed(64'(intv_reg)));

    // memory access: append on request, move tail into freed slot on fire
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = mem_rdata;
        if (state_reg == lcts_pkg::ST_MOVE)
        begin
            mem_we = 1'b1;
        end
        else if (take && cmd.mode == lcts_pkg::MODE_REQUEST && req_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[AW-1:0];
            mem_wdata = t_in;
        end
        if (state_reg == lcts_pkg::ST_SCAN)
        begin
            mem_raddr = idx_reg;
        end
        else
        begin
            mem_raddr = count_m1[AW-1:0];
        end
    end

    lcts_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TIME_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcts_pkg::ST_IDLE:
            begin
                if (take && cmd.mode == lcts_pkg::MODE_TICK &&
                    session_reg == lcts_pkg::SESSION_STARTED)
                begin
                    state_next = (count_reg == '0) ? lcts_pkg::ST_PULSE
                                                   : lcts_pkg::ST_SCAN;
                end
            end
            lcts_pkg::ST_SCAN:
            begin
                if (CW'(idx_reg) == count_m1)
                begin
                    state_next = lcts_pkg::ST_SDRAIN;
                end
            end
            lcts_pkg::ST_SDRAIN: state_next = lcts_pkg::ST_CHECK;
            lcts_pkg::ST_CHECK:
            begin
                state_next = (due && link_reg) ? lcts_pkg::ST_MOVE
                                               : lcts_pkg::ST_PULSE;
            end
            lcts_pkg::ST_MOVE:
            begin
                state_next = (count_reg == '0) ? lcts_pkg::ST_PULSE
                                               : lcts_pkg::ST_SCAN;
            end
            lcts_pkg::ST_PULSE: state_next = lcts_pkg::ST_FLUSH;
            lcts_pkg::ST_FLUSH: state_next = lcts_pkg::ST_IDLE;
            default:            state_next = lcts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lcts_pkg::ST_IDLE;
            tol_reg        <= '0;
            intv_reg       <= lcts_pkg::IntervalReset;
            count_reg      <= '0;
            lat_reg        <= '0;
            pulse_t_reg    <= '0;
            corr_reg       <= '0;
            session_reg    <= lcts_pkg::SESSION_STOPPED;
            link_reg       <= 1'b0;
            idx_reg        <= '0;
            rv_reg         <= 1'b0;
            hold_valid_reg <= 1'b0;
            res_valid      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid <= 1'b0;
            rv_reg    <= (state_reg == lcts_pkg::ST_SCAN);

            if (cfg_we)
            begin
                if (cfg_index == lcts_pkg::REG_TOLERANCE)
                begin
                    tol_reg <= cfg_data[lcts_pkg::TolW-1:0];
                end
                else
                begin
                    intv_reg <= cfg_data;
                end
            end

            if (state_reg == lcts_pkg::ST_IDLE && take)
            begin
                case (cmd.mode)
                    lcts_pkg::MODE_TICK:
                    begin
                        if (session_reg == lcts_pkg::SESSION_STARTED)
                        begin
                            corr_reg <= corr_sat;
                            idx_reg  <= '0;
                        end
                    end
                    lcts_pkg::MODE_REQUEST:
                    begin
                        if (req_ok)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        res_valid <= 1'b1;
                    end
                    lcts_pkg::MODE_ECHO:
                    begin
                        lat_reg   <= lat_sat;
                        res_valid <= 1'b1;
                    end
                    lcts_pkg::MODE_SESSION:
                    begin
                        if (cmd.session_code != session_reg)
                        begin
                            session_reg <= cmd.session_code;
                            if (cmd.session_code == lcts_pkg::SESSION_STOPPED)
                            begin
                                lat_reg     <= '0;
                                pulse_t_reg <= '0;
                            end
                        end
                    end
                    lcts_pkg::MODE_LINK:
                    begin
                        link_reg <= cmd.link_on;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == lcts_pkg::ST_SCAN)
            begin
                idx_reg <= idx_reg + AW'(1);
            end

            if (state_reg == lcts_pkg::ST_MOVE)
            begin
                idx_reg <= '0;
            end

            // fire: drop the entry from the count, hold its beat
            if (state_reg == lcts_pkg::ST_CHECK && due && link_reg)
            begin
                count_reg      <= count_m1;
                hold_valid_reg <= 1'b1;
                res_valid      <= hold_valid_reg;
            end

            if (state_reg == lcts_pkg::ST_PULSE && pulse_ok)
            begin
                pulse_t_reg    <= tick_t_reg;
                hold_valid_reg <= 1'b1;
                res_valid      <= hold_valid_reg;
            end

            if (state_reg == lcts_pkg::ST_FLUSH)
            begin
                hold_valid_reg <= 1'b0;
                res_valid      <= hold_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == lcts_pkg::ST_IDLE && take)
        begin
            tick_t_reg <= t_in;
            res.kind           <= (cmd.mode == lcts_pkg::MODE_ECHO) ?
                                  lcts_pkg::KIND_LATENCY : lcts_pkg::KIND_DECISION;
            res.fire_time      <= lcts_pkg::CmdTimeW'(t_in);
            res.corrected_time <= corr_reg;
            res.latency_now    <= (cmd.mode == lcts_pkg::MODE_ECHO) ? lat_sat : lat_reg;
            res.accepted       <= (cmd.mode == lcts_pkg::MODE_REQUEST) && req_ok;
            res.last           <= 1'b1;
        end

        // keep the earliest entry, first index on a tie
        if (rv_reg && (rv_idx_reg == '0 || mem_rdata < best_val_reg))
        begin
            best_val_reg <= mem_rdata;
            best_idx_reg <= rv_idx_reg;
        end
        rv_idx_reg <= idx_reg;

        if ((state_reg == lcts_pkg::ST_CHECK && due && link_reg) ||
            (state_reg == lcts_pkg::ST_PULSE && pulse_ok))
        begin
            res.kind           <= hold_reg.kind;
            res.fire_time      <= hold_reg.fire_time;
            res.corrected_time <= hold_reg.corrected_time;
            res.latency_now    <= hold_reg.latency_now;
            res.accepted       <= hold_reg.accepted;
            res.last           <= 1'b0;
            hold_reg.kind           <= (state_reg == lcts_pkg::ST_CHECK) ?
                                       lcts_pkg::KIND_FIRE : lcts_pkg::KIND_PULSE;
            hold_reg.fire_time      <= (state_reg == lcts_pkg::ST_CHECK) ?
                                       lcts_pkg::CmdTimeW'(best_val_reg) :
                                       lcts_pkg::CmdTimeW'(tick_t_reg);
            hold_reg.corrected_time <= corr_reg;
            hold_reg.latency_now    <= lat_reg;
            hold_reg.accepted       <= 1'b0;
            hold_reg.last           <= 1'b1;
        end

        if (state_reg == lcts_pkg::ST_FLUSH)
        begin
            res <= hold_reg;
        end
    end

    // a beat that is not last only comes out while a tick is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |-> busy)
        else $error("non-final beat outside a tick");

    // the queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountFull)
        else $error("queue count overflow");

    // a search only runs over a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lcts_pkg::ST_SCAN |-> count_reg != '0)
        else $error("search of an empty queue");

endmodule
`default_nettype wire

[tb/latency_corrected_trigger_scheduler_core_test.sv]
// Self-checking testbench for the latency-corrected trigger scheduler core.
// Depends on lcts_pkg and the core RTL. Commands go in one at a time and every
// result beat is checked against an in-bench prediction of the block.
`timescale 1ns / 100ps
module latency_corrected_trigger_scheduler_core_test;

    localparam int   SlotCount  = 16;
    localparam int   StallLimit = 20000;
    localparam longint CorrMax  = (64'sd1 <<< 47) - 1;
    localparam longint CorrMin  = -(64'sd1 <<< 47);
    localparam logic [45:0] TimeMax = '1;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    lcts_pkg::cmd_t                cmd;
    logic                          res_valid;
    lcts_pkg::res_t                res;
    logic                          cfg_we;
    logic                          cfg_index;
    logic [lcts_pkg::CfgDataW-1:0] cfg_data;

    latency_corrected_trigger_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow of the scheduler: registers, trigger queue and timing state.
    logic [19:0] tol_shadow;
    logic [23:0] intv_shadow;
    logic [45:0] slot_time [SlotCount];
    int          slot_count;
    int          latency_shadow;
    longint      pulse_time;
    longint      corr_now;
    logic [1:0]  session_shadow;
    logic        link_shadow;

    lcts_pkg::res_t pending_beats [$];
    int     error_count;
    int     idle_pct;
    longint sim_now;   // running sample time for well-formed random traffic

    function automatic lcts_pkg::res_t make_beat(logic [1:0] k, longint sched, logic acc);
        lcts_pkg::res_t r;
        r.kind           = k;
        r.fire_time      = sched[45:0];
        r.corrected_time = corr_now[47:0];
        r.latency_now    = latency_shadow;
        r.accepted       = acc;
        r.last           = 1'b0;
        return r;
    endfunction

    // Advance the shadow by one accepted command and queue the beats it causes.
    task automatic predict_cmd(input lcts_pkg::cmd_t c);
        longint t;
        longint v;
        lcts_pkg::res_t beats [$];
        int     best;
        logic   ok;
        t = longint'({18'd0, c.time_us});
        case (c.mode)
            lcts_pkg::MODE_TICK:
            begin
                if (session_shadow == lcts_pkg::SESSION_STARTED)
                begin
                    v = t + longint'(latency_shadow);
                    corr_now = (v > CorrMax) ? CorrMax : ((v < CorrMin) ? CorrMin : v);
                    // drain due entries earliest first; halt while the link is down
                    while (slot_count > 0)
                    begin
                        best = 0;
                        for (int i = 1; i < slot_count; i++)
                            if (slot_time[i] < slot_time[best])
                                best = i;
                        if (longint'({18'd0, slot_time[best]}) > corr_now || !link_shadow)
                            break;
                        v = longint'({18'd0, slot_time[best]});
                        slot_count--;
                        slot_time[best] = slot_time[slot_count];
                        beats.push_back(make_beat(lcts_pkg::KIND_FIRE, v, 1'b0));
                    end
                    if (t - pulse_time >= longint'({40'd0, intv_shadow}) && link_shadow)
                    begin
                        pulse_time = t;
                        beats.push_back(make_beat(lcts_pkg::KIND_PULSE, t, 1'b0));
                    end
                end
            end
            lcts_pkg::MODE_REQUEST:
            begin
                ok = link_shadow && slot_count < SlotCount &&
                     t > corr_now - longint'({44'd0, tol_shadow});
                if (ok)
                begin
                    slot_time[slot_count] = c.time_us;
                    slot_count++;
                end
                beats.push_back(make_beat(lcts_pkg::KIND_DECISION, t, ok));
            end
            lcts_pkg::MODE_ECHO:
            begin
                v = t - pulse_time;
                latency_shadow = (v > 64'sd2147483647) ? 32'h7fffffff :
                                 ((v < -64'sd2147483648) ? 32'h80000000 : int'(v));
                beats.push_back(make_beat(lcts_pkg::KIND_LATENCY, t, 1'b0));
            end
            lcts_pkg::MODE_SESSION:
            begin
                if (c.session_code != session_shadow)
                begin
                    session_shadow = c.session_code;
                    if (c.session_code == lcts_pkg::SESSION_STOPPED)
                    begin
                        latency_shadow = 0;
                        pulse_time     = 0;
                    end
                end
            end
            lcts_pkg::MODE_LINK:
                link_shadow = c.link_on;
            default: ;
        endcase
        if (beats.size() > 0)
            beats[beats.size() - 1].last = 1'b1;
        foreach (beats[i])
            pending_beats.push_back(beats[i]);
    endtask

    // Offer one command; hold start until taken, then maybe drop it for a gap.
    task automatic send_cmd(input logic [2:0] m, input logic [45:0] t,
                            input logic [1:0] sc, input logic lk);
        lcts_pkg::cmd_t c;
        c.mode         = m;
        c.time_us      = t;
        c.session_code = sc;
        c.link_on      = lk;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        predict_cmd(c);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Drop start, wait for every beat, then let a silent tick finish.
    task automatic settle();
        start <= 1'b0;
        while (pending_beats.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [lcts_pkg::CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == lcts_pkg::REG_TOLERANCE)
            tol_shadow = val[19:0];
        else
            intv_shadow = val;
        cfg_we <= 1'b0;
    endtask

    // Everything before link-up and session start must be inert or rejected.
    task automatic test_idle_defaults();
        send_cmd(lcts_pkg::MODE_TICK, 46'd500000, 2'd1, 1'b1);
        send_cmd(lcts_pkg::MODE_REQUEST, 46'd10, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_ECHO, 46'd0, 2'd0, 1'b0);
        send_cmd(3'd5, TimeMax, 2'd3, 1'b1);
        send_cmd(3'd6, 46'd0, 2'd0, 1'b0);
        send_cmd(3'd7, TimeMax, 2'd1, 1'b1);
    endtask

    // Field extremes, latency saturation, session codes and the zero interval.
    task automatic test_extremes();
        send_cmd(lcts_pkg::MODE_LINK, 46'd0, 2'd0, 1'b1);
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, lcts_pkg::SESSION_STARTED, 1'b0);
        send_cmd(lcts_pkg::MODE_TICK, TimeMax, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_ECHO, 46'd0, 2'd0, 1'b0);       // latency saturates low
        send_cmd(lcts_pkg::MODE_TICK, 46'd0, 2'd0, 1'b0);       // earlier than last pulse
        send_cmd(lcts_pkg::MODE_REQUEST, 46'd0, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_REQUEST, TimeMax, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, lcts_pkg::SESSION_STOPPED, 1'b0);
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, lcts_pkg::SESSION_STARTED, 1'b0);
        send_cmd(lcts_pkg::MODE_TICK, 46'd5, 2'd0, 1'b0);       // fires time zero, pulses
        send_cmd(lcts_pkg::MODE_ECHO, TimeMax, 2'd0, 1'b0);     // latency saturates high
        send_cmd(lcts_pkg::MODE_TICK, 46'd6, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, 2'd2, 1'b0);
        send_cmd(lcts_pkg::MODE_TICK, 46'd7, 2'd0, 1'b0);       // not started: silent
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, 2'd3, 1'b0);
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, 2'd3, 1'b0);    // unchanged code
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, lcts_pkg::SESSION_STOPPED, 1'b0);
        send_cmd(lcts_pkg::MODE_SESSION, 46'd0, lcts_pkg::SESSION_STARTED, 1'b0);
    endtask

    // Fill the queue (with duplicates), overflow it, and tick with the link down.
    task automatic test_queue_full();
        // pull the corrected time back to zero so the requests are in the future
        send_cmd(lcts_pkg::MODE_TICK, 46'd0, 2'd0, 1'b0);
        for (int i = 0; i < SlotCount; i++)
            send_cmd(lcts_pkg::MODE_REQUEST, 46'(1000 + (i % 12)), 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_REQUEST, 46'd1500, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_LINK, 46'd0, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_TICK, 46'd2000, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_LINK, 46'd0, 2'd0, 1'b1);
        send_cmd(lcts_pkg::MODE_TICK, 46'd1004, 2'd0, 1'b0);
        send_cmd(lcts_pkg::MODE_TICK, 46'd3000, 2'd0, 1'b0);
    endtask

    // Mostly coherent traffic around a running clock, with some raw noise.
    task automatic test_random_traffic(input int count);
        int     pick;
        longint t;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pulse_time > sim_now)
                sim_now = pulse_time;
            if (pick < 10)
                send_cmd(3'($urandom_range(7)), 46'({$urandom, $urandom}),
                         2'($urandom_range(3)), 1'($urandom_range(1)));
            else if (pick < 50)
            begin
                sim_now += ($urandom_range(9) == 0) ? $urandom_range(200000)
                                                    : $urandom_range(3000);
                send_cmd(lcts_pkg::MODE_TICK, 46'(sim_now), 2'($urandom_range(3)),
                         1'($urandom_range(1)));
            end
            else if (pick < 80)
            begin
                t = sim_now + longint'(latency_shadow) +
                    longint'($urandom_range(20000)) - 64'sd5000;
                if (t < 0)
                    t = 0;
                send_cmd(lcts_pkg::MODE_REQUEST, 46'(t), 2'($urandom_range(3)),
                         1'($urandom_range(1)));
            end
            else if (pick < 88)
                send_cmd(lcts_pkg::MODE_ECHO, 46'(pulse_time + $urandom_range(3000)),
                         2'($urandom_range(3)), 1'($urandom_range(1)));
            else if (pick < 94)
                send_cmd(lcts_pkg::MODE_LINK, 46'({$urandom, $urandom}),
                         2'($urandom_range(3)), 1'($urandom_range(9) != 0));
            else
            begin
                // a random session code, then a start; a stop code also clears the pulse time
                send_cmd(lcts_pkg::MODE_SESSION, 46'd0, 2'($urandom_range(3)), 1'b0);
                send_cmd(lcts_pkg::MODE_SESSION, 46'd0, lcts_pkg::SESSION_STARTED, 1'b0);
            end
        end
    endtask

    // Compare each beat with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        lcts_pkg::res_t want;
        if (rst_n && res_valid)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat kind=%0d", res.kind);
                error_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (res.kind !== want.kind)
                begin
                    $error("kind: expected %0d got %0d", want.kind, res.kind);
                    error_count++;
                end
                if (res.fire_time !== want.fire_time)
                begin
                    $error("fire_time: expected %0d got %0d",
                           want.fire_time, res.fire_time);
                    error_count++;
                end
                if (res.corrected_time !== want.corrected_time)
                begin
                    $error("corrected_time: expected %0d got %0d",
                           want.corrected_time, res.corrected_time);
                    error_count++;
                end
                if (res.latency_now !== want.latency_now)
                begin
                    $error("latency_now: expected %0d got %0d",
                           want.latency_now, res.latency_now);
                    error_count++;
                end
                if (res.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d got %0d", want.accepted, res.accepted);
                    error_count++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0d got %0d", want.last, res.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves either way.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if ((start && !busy) || res_valid || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit)
        begin
            $display("latency_corrected_trigger_scheduler_core_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        cmd            <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= 1'b0;
        cfg_data       <= '0;
        error_count    = 0;
        idle_pct       = 0;
        tol_shadow     = '0;
        intv_shadow    = lcts_pkg::IntervalReset;
        slot_count     = 0;
        latency_shadow = 0;
        pulse_time     = 0;
        corr_now       = 0;
        session_shadow = lcts_pkg::SESSION_STOPPED;
        link_shadow    = 1'b0;
        sim_now        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_defaults();
        settle();
        write_reg(lcts_pkg::REG_TOLERANCE, 24'd1000000);
        write_reg(lcts_pkg::REG_INTERVAL, 24'd0);
        test_extremes();
        settle();
        write_reg(lcts_pkg::REG_TOLERANCE, 24'd0);
        write_reg(lcts_pkg::REG_INTERVAL, 24'd10000000);
        test_queue_full();
        settle();

        // Random phases: vary the gap rate and walk the registers through settings.
        sim_now = $urandom_range(1 << 30);
        write_reg(lcts_pkg::REG_TOLERANCE, 24'd2000);
        write_reg(lcts_pkg::REG_INTERVAL, 24'd100000);
        idle_pct = 0;
        test_random_traffic(21);
        settle();
        write_reg(lcts_pkg::REG_TOLERANCE, 24'd1000000);
        write_reg(lcts_pkg::REG_INTERVAL, 24'd1);
        idle_pct = 49;
        test_random_traffic(21);
        settle();
        write_reg(lcts_pkg::REG_TOLERANCE, 24'd0);
        write_reg(lcts_pkg::REG_INTERVAL, 24'd0);
        idle_pct = 0;
        test_random_traffic(21);
        settle();
        write_reg(lcts_pkg::REG_TOLERANCE, 24'd500);
        write_reg(lcts_pkg::REG_INTERVAL, 24'hffffff);
        idle_pct = 33;
        test_random_traffic(21);
        settle();

        if (error_count == 0)
            $display("latency_corrected_trigger_scheduler_core_test OK");
        else
            $display("latency_corrected_trigger_scheduler_core_test NOT OK");
        $finish;
    end

endmodule

[files.f]
rtl/lcts_pkg.sv
rtl/lcts_queue_mem.sv
rtl/latency_corrected_trigger_scheduler_core.sv
tb/latency_corrected_trigger_scheduler_core_test.sv
